// ===== rtl/kf2d_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kf2d_pkg: shared types, codes and microcode for the 2-state Kalman filter
// Holds the operation codes, register indexes, operand slots, the shared unit
// request struct and the microcode store that drives the sequencer.
// ----------------------------------------------------------------------------
package kf2d_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int WORD_BITS_DEF = 32;
    localparam int PC_BITS       = 7;
    localparam int NUM_CFG       = 8;
    localparam int NUM_ST        = 20;

    // input operation codes
    localparam logic [2:0] OP_RESTART   = 3'd0;
    localparam logic [2:0] OP_PREDICT   = 3'd1;
    localparam logic [2:0] OP_PRED_ACC  = 3'd2;
    localparam logic [2:0] OP_UPD_POS   = 3'd3;
    localparam logic [2:0] OP_UPD_BOTH  = 3'd4;

    // configuration register indexes
    localparam logic [2:0] REG_Q_POS    = 3'd0;
    localparam logic [2:0] REG_Q_VEL    = 3'd1;
    localparam logic [2:0] REG_R_POS    = 3'd2;
    localparam logic [2:0] REG_R_VEL    = 3'd3;
    localparam logic [2:0] REG_INIT_POS = 3'd4;
    localparam logic [2:0] REG_INIT_VEL = 3'd5;
    localparam logic [2:0] REG_INIT_PPV = 3'd6;
    localparam logic [2:0] REG_INIT_VVV = 3'd7;

    localparam logic [31:0] CFG_RESET [NUM_CFG] = '{
        32'd655, 32'd6554, 32'd32768, 32'd65536000,
        32'd0, 32'd0, 32'd6553600, 32'd6553600
    };

    // microcode program entry points
    localparam logic [PC_BITS-1:0] PC_RESTART  = 7'd0;
    localparam logic [PC_BITS-1:0] PC_PRED_ACC = 7'd11;
    localparam logic [PC_BITS-1:0] PC_PREDICT  = 7'd20;
    localparam logic [PC_BITS-1:0] PC_COV      = 7'd22;
    localparam logic [PC_BITS-1:0] PC_UPD_POS  = 7'd34;
    localparam logic [PC_BITS-1:0] PC_UPD_BOTH = 7'd52;
    localparam logic [PC_BITS-1:0] PC_HALT     = 7'd104;

    typedef enum logic [2:0] {
        UC_ADD, UC_SUB, UC_MUL, UC_DIV, UC_DIVP, UC_BRZ, UC_JMP, UC_END
    } t_uop;

    // operand slots: writable state and temporaries first, then read-only sources
    typedef enum logic [5:0] {
        S_POS, S_VEL, S_P0, S_P1, S_P2, S_P3, S_K0, S_K1, S_K2, S_K3,
        S_T0, S_T1, S_T2, S_T3, S_T4, S_T5, S_T6, S_T7, S_T8, S_T9,
        S_DT, S_ACC, S_ZP, S_ZV, S_ZERO, S_ONE, S_HALF,
        S_QP, S_QV, S_RP, S_RV, S_IP, S_IV, S_IPV, S_IVV
    } t_slot;

    typedef struct packed {
        t_uop               op;
        t_slot              a;
        t_slot              b;
        t_slot              d;
        logic [PC_BITS-1:0] tgt;
    } t_uinst;

    typedef struct packed {
        logic start;
        t_uop op;
    } t_alu_req;

    function automatic t_uinst f_u(input t_uop op, input t_slot a, input t_slot b,
                                   input t_slot d);
        t_uinst r;
        r.op  = op;
        r.a   = a;
        r.b   = b;
        r.d   = d;
        r.tgt = '0;
        return r;
    endfunction

    function automatic t_uinst f_ucode(input logic [PC_BITS-1:0] pc);
        t_uinst r;
        r = f_u(UC_END, S_ZERO, S_ZERO, S_ZERO);
        case (pc)
            // restart from configured values
            7'd0:   r = f_u(UC_ADD, S_IP,   S_ZERO, S_POS);
            7'd1:   r = f_u(UC_ADD, S_IV,   S_ZERO, S_VEL);
            7'd2:   r = f_u(UC_ADD, S_IPV,  S_ZERO, S_P0);
            7'd3:   r = f_u(UC_ADD, S_ZERO, S_ZERO, S_P1);
            7'd4:   r = f_u(UC_ADD, S_ZERO, S_ZERO, S_P2);
            7'd5:   r = f_u(UC_ADD, S_IVV,  S_ZERO, S_P3);
            7'd6:   r = f_u(UC_ADD, S_ZERO, S_ZERO, S_K0);
            7'd7:   r = f_u(UC_ADD, S_ZERO, S_ZERO, S_K1);
            7'd8:   r = f_u(UC_ADD, S_ZERO, S_ZERO, S_K2);
            7'd9:   r = f_u(UC_ADD, S_ZERO, S_ZERO, S_K3);
            // predict with acceleration
            7'd11:  r = f_u(UC_MUL, S_HALF, S_ACC,  S_T0);
            7'd12:  r = f_u(UC_MUL, S_T0,   S_DT,   S_T0);
            7'd13:  r = f_u(UC_MUL, S_T0,   S_DT,   S_T0);
            7'd14:  r = f_u(UC_MUL, S_VEL,  S_DT,   S_T1);
            7'd15:  r = f_u(UC_ADD, S_T1,   S_T0,   S_T0);
            7'd16:  r = f_u(UC_ADD, S_POS,  S_T0,   S_POS);
            7'd17:  r = f_u(UC_MUL, S_ACC,  S_DT,   S_T1);
            7'd18:  r = f_u(UC_ADD, S_VEL,  S_T1,   S_VEL);
            7'd19: begin
                r     = f_u(UC_JMP, S_ZERO, S_ZERO, S_ZERO);
                r.tgt = PC_COV;
            end
            // plain predict
            7'd20:  r = f_u(UC_MUL, S_VEL,  S_DT,   S_T0);
            7'd21:  r = f_u(UC_ADD, S_POS,  S_T0,   S_POS);
            // covariance predict
            7'd22:  r = f_u(UC_MUL, S_DT,   S_P2,   S_T1);
            7'd23:  r = f_u(UC_ADD, S_P0,   S_T1,   S_T1);
            7'd24:  r = f_u(UC_MUL, S_DT,   S_P3,   S_T2);
            7'd25:  r = f_u(UC_ADD, S_P1,   S_T2,   S_T2);
            7'd26:  r = f_u(UC_MUL, S_T2,   S_DT,   S_T3);
            7'd27:  r = f_u(UC_ADD, S_T1,   S_T3,   S_T3);
            7'd28:  r = f_u(UC_ADD, S_T3,   S_QP,   S_P0);
            7'd29:  r = f_u(UC_ADD, S_T2,   S_ZERO, S_P1);
            7'd30:  r = f_u(UC_MUL, S_P3,   S_DT,   S_T4);
            7'd31:  r = f_u(UC_ADD, S_P2,   S_T4,   S_P2);
            7'd32:  r = f_u(UC_ADD, S_P3,   S_QV,   S_P3);
            // position-only update
            7'd34:  r = f_u(UC_ADD,  S_P0,  S_RP,   S_T0);
            7'd35:  r = f_u(UC_DIVP, S_P0,  S_T0,   S_K0);
            7'd36:  r = f_u(UC_DIVP, S_P2,  S_T0,   S_K2);
            7'd37:  r = f_u(UC_ADD, S_ZERO, S_ZERO, S_K1);
            7'd38:  r = f_u(UC_ADD, S_ZERO, S_ZERO, S_K3);
            7'd39:  r = f_u(UC_SUB, S_ZP,   S_POS,  S_T1);
            7'd40:  r = f_u(UC_MUL, S_K0,   S_T1,   S_T2);
            7'd41:  r = f_u(UC_ADD, S_POS,  S_T2,   S_POS);
            7'd42:  r = f_u(UC_MUL, S_K2,   S_T1,   S_T2);
            7'd43:  r = f_u(UC_ADD, S_VEL,  S_T2,   S_VEL);
            7'd44:  r = f_u(UC_SUB, S_ONE,  S_K0,   S_T3);
            7'd45:  r = f_u(UC_MUL, S_K2,   S_P0,   S_T2);
            7'd46:  r = f_u(UC_SUB, S_P2,   S_T2,   S_P2);
            7'd47:  r = f_u(UC_MUL, S_K2,   S_P1,   S_T2);
            7'd48:  r = f_u(UC_SUB, S_P3,   S_T2,   S_P3);
            7'd49:  r = f_u(UC_MUL, S_T3,   S_P0,   S_P0);
            7'd50:  r = f_u(UC_MUL, S_T3,   S_P1,   S_P1);
            // position and velocity update
            7'd52:  r = f_u(UC_ADD, S_P0,   S_RP,   S_T0);
            7'd53:  r = f_u(UC_ADD, S_P3,   S_RV,   S_T1);
            7'd54:  r = f_u(UC_MUL, S_T0,   S_T1,   S_T2);
            7'd55:  r = f_u(UC_MUL, S_P1,   S_P2,   S_T3);
            7'd56:  r = f_u(UC_SUB, S_T2,   S_T3,   S_T2);
            7'd57:  r = f_u(UC_BRZ, S_T2,   S_ZERO, S_ZERO);
            7'd58:  r = f_u(UC_MUL, S_P0,   S_T1,   S_T3);
            7'd59:  r = f_u(UC_MUL, S_P1,   S_P2,   S_T4);
            7'd60:  r = f_u(UC_SUB, S_T3,   S_T4,   S_T3);
            7'd61:  r = f_u(UC_DIV, S_T3,   S_T2,   S_K0);
            7'd62:  r = f_u(UC_MUL, S_P1,   S_T0,   S_T3);
            7'd63:  r = f_u(UC_MUL, S_P0,   S_P1,   S_T4);
            7'd64:  r = f_u(UC_SUB, S_T3,   S_T4,   S_T3);
            7'd65:  r = f_u(UC_DIV, S_T3,   S_T2,   S_K1);
            7'd66:  r = f_u(UC_MUL, S_P2,   S_T1,   S_T3);
            7'd67:  r = f_u(UC_MUL, S_P3,   S_P2,   S_T4);
            7'd68:  r = f_u(UC_SUB, S_T3,   S_T4,   S_T3);
            7'd69:  r = f_u(UC_DIV, S_T3,   S_T2,   S_K2);
            7'd70:  r = f_u(UC_MUL, S_P3,   S_T0,   S_T3);
            7'd71:  r = f_u(UC_MUL, S_P2,   S_P1,   S_T4);
            7'd72:  r = f_u(UC_SUB, S_T3,   S_T4,   S_T3);
            7'd73:  r = f_u(UC_DIV, S_T3,   S_T2,   S_K3);
            7'd74:  r = f_u(UC_SUB, S_ZP,   S_POS,  S_T3);
            7'd75:  r = f_u(UC_SUB, S_ZV,   S_VEL,  S_T4);
            7'd76:  r = f_u(UC_MUL, S_K0,   S_T3,   S_T5);
            7'd77:  r = f_u(UC_MUL, S_K1,   S_T4,   S_T6);
            7'd78:  r = f_u(UC_ADD, S_T5,   S_T6,   S_T5);
            7'd79:  r = f_u(UC_ADD, S_POS,  S_T5,   S_POS);
            7'd80:  r = f_u(UC_MUL, S_K2,   S_T3,   S_T5);
            7'd81:  r = f_u(UC_MUL, S_K3,   S_T4,   S_T6);
            7'd82:  r = f_u(UC_ADD, S_T5,   S_T6,   S_T5);
            7'd83:  r = f_u(UC_ADD, S_VEL,  S_T5,   S_VEL);
            7'd84:  r = f_u(UC_SUB, S_ONE,  S_K0,   S_T3);
            7'd85:  r = f_u(UC_SUB, S_ZERO, S_K1,   S_T4);
            7'd86:  r = f_u(UC_SUB, S_ZERO, S_K2,   S_T5);
            7'd87:  r = f_u(UC_SUB, S_ONE,  S_K3,   S_T6);
            7'd88:  r = f_u(UC_MUL, S_T3,   S_P0,   S_T7);
            7'd89:  r = f_u(UC_MUL, S_T4,   S_P2,   S_T8);
            7'd90:  r = f_u(UC_ADD, S_T7,   S_T8,   S_T7);
            7'd91:  r = f_u(UC_MUL, S_T3,   S_P1,   S_T8);
            7'd92:  r = f_u(UC_MUL, S_T4,   S_P3,   S_T9);
            7'd93:  r = f_u(UC_ADD, S_T8,   S_T9,   S_T8);
            7'd94:  r = f_u(UC_MUL, S_T5,   S_P0,   S_T9);
            7'd95:  r = f_u(UC_MUL, S_T6,   S_P2,   S_T0);
            7'd96:  r = f_u(UC_ADD, S_T9,   S_T0,   S_T9);
            7'd97:  r = f_u(UC_MUL, S_T5,   S_P1,   S_T0);
            7'd98:  r = f_u(UC_MUL, S_T6,   S_P3,   S_T1);
            7'd99:  r = f_u(UC_ADD, S_T0,   S_T1,   S_T0);
            7'd100: r = f_u(UC_ADD, S_T7,   S_ZERO, S_P0);
            7'd101: r = f_u(UC_ADD, S_T8,   S_ZERO, S_P1);
            7'd102: r = f_u(UC_ADD, S_T9,   S_ZERO, S_P2);
            7'd103: r = f_u(UC_ADD, S_T0,   S_ZERO, S_P3);
            default: r = f_u(UC_END, S_ZERO, S_ZERO, S_ZERO);
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/kf2d_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kf2d_alu: shared saturating fixed-point arithmetic unit
// Add and subtract into the result register, multiply via a product register
// then round and saturate; bit-serial divide, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module kf2d_alu #(
    parameter int WORD_BITS = kf2d_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = kf2d_pkg::FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  kf2d_pkg::t_alu_req          i_req,
    input  logic signed [WORD_BITS-1:0] i_a,
    input  logic signed [WORD_BITS-1:0] i_b,
    output logic                        o_done,
    output logic signed [WORD_BITS-1:0] o_res
);
    localparam int W  = WORD_BITS;
    localparam int MW = 2 * W + 1;
    localparam int NW = W + FRAC_BITS;
    localparam int CW = $clog2(NW + 1);

    typedef enum logic [2:0] {
        A_IDLE = 3'b001,
        A_MUL  = 3'b010,
        A_DIV  = 3'b100
    } t_astate;

    t_astate              r_state;
    logic                 r_done;
    logic signed [W-1:0]  r_res;
    logic                 r_neg;
    logic [2*W-1:0]       r_prod;
    logic [NW-1:0]        r_num;
    logic [NW-1:0]        r_quo;
    logic [W-1:0]         r_den;
    logic [W-1:0]         r_rem;
    logic [CW-1:0]        r_cnt;

    logic [W-1:0]         w_ma;
    logic [W-1:0]         w_mb;
    logic                 w_neg;
    logic signed [W:0]    w_sum;
    logic signed [W:0]    w_dif;
    logic [MW-1:0]        w_rnd;
    logic [W:0]           w_rsh;
    logic                 w_ge;
    logic [W:0]           w_rdf;

    // saturate an unsigned magnitude with a sign into the word range
    function automatic logic signed [W-1:0] f_from_mag(input logic neg,
                                                       input logic [MW-1:0] m);
        logic [MW-1:0] lim;
        logic [MW-1:0] mm;
        lim = (MW'(1) << (W - 1)) - (neg ? MW'(0) : MW'(1));
        mm  = (m > lim) ? lim : m;
        return neg ? -$signed(mm[W-1:0]) : $signed(mm[W-1:0]);
    endfunction

    function automatic logic signed [W-1:0] f_sat(input logic signed [W:0] v);
        if (v[W] != v[W-1]) begin
            return v[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end
        return v[W-1:0];
    endfunction

    // operand magnitudes and sign
    assign w_ma  = i_a[W-1] ? (~i_a + 1'b1) : i_a;
    assign w_mb  = i_b[W-1] ? (~i_b + 1'b1) : i_b;
    assign w_neg = i_a[W-1] ^ i_b[W-1];
    assign w_sum = {i_a[W-1], i_a} + {i_b[W-1], i_b};
    assign w_dif = {i_a[W-1], i_a} - {i_b[W-1], i_b};

    // rounding of the registered product
    assign w_rnd = ({1'b0, r_prod} + (MW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;

    // one restoring division step
    assign w_rsh = {r_rem, r_num[NW-1]};
    assign w_ge  = w_rsh >= {1'b0, r_den};
    assign w_rdf = w_rsh - {1'b0, r_den};

    // sequencing of the shared unit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                A_IDLE: begin
                    if (i_req.start) begin
                        case (i_req.op) inside
                            kf2d_pkg::UC_ADD: begin
                                r_res  <= f_sat(w_sum);
                                r_done <= 1'b1;
                            end
                            kf2d_pkg::UC_SUB: begin
                                r_res  <= f_sat(w_dif);
                                r_done <= 1'b1;
                            end
                            kf2d_pkg::UC_MUL: begin
                                r_prod  <= w_ma * w_mb;
                                r_neg   <= w_neg;
                                r_state <= A_MUL;
                            end
                            kf2d_pkg::UC_DIV, kf2d_pkg::UC_DIVP: begin
                                if (i_b == '0 ||
                                    (i_req.op == kf2d_pkg::UC_DIVP && i_b[W-1])) begin
                                    r_res  <= '0;
                                    r_done <= 1'b1;
                                end else begin
                                    r_num   <= {w_ma, {FRAC_BITS{1'b0}}};
                                    r_den   <= w_mb;
                                    r_rem   <= '0;
                                    r_quo   <= '0;
                                    r_neg   <= w_neg;
                                    r_cnt   <= CW'(NW);
                                    r_state <= A_DIV;
                                end
                            end
                            default: begin
                                r_res  <= '0;
                                r_done <= 1'b1;
                            end
                        endcase
                    end
                end
                A_MUL: begin
                    r_res   <= f_from_mag(r_neg, w_rnd);
                    r_done  <= 1'b1;
                    r_state <= A_IDLE;
                end
                A_DIV: begin
                    r_num <= {r_num[NW-2:0], 1'b0};
                    r_rem <= w_ge ? w_rdf[W-1:0] : w_rsh[W-1:0];
                    r_quo <= {r_quo[NW-2:0], w_ge};
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == CW'(1)) begin
                        r_res   <= f_from_mag(r_neg, MW'({r_quo[NW-2:0], w_ge}));
                        r_done  <= 1'b1;
                        r_state <= A_IDLE;
                    end
                end
                default: r_state <= A_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

// ===== rtl/kalman_filter_2d_pos_vel.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kalman_filter_2d_pos_vel: two-state position/velocity Kalman filter
// Microcoded sequencer around one shared saturating add/multiply/divide unit.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one request: tuser = operation, tdata = time_step,
//   acceleration, meas_position, meas_velocity. Every request gives one
//   result on m_axis: tdata = position, velocity, four covariance entries,
//   four gain entries; tuser = update_skipped. Configuration registers are
//   written through i_cfg_we/i_cfg_idx/i_cfg_data by the user, who must do so
//   only while the filter is idle; the block itself does not enforce this.
// Sequencing:
//   each microcode step is a jump or branch in the sequencer alone, or an
//   add/sub, multiply or bit-serial divide on the shared unit. A divide by
//   zero, or a position-update divide by a negative divisor, gives zero
//   without the division steps. The two-measurement update is skipped when
//   its determinant is zero. After the last step the result is loaded into
//   the output register. Arithmetic is Q16.16 at the default widths.
//   s_axis_tready is high only while the sequencer is idle, so a new request
//   is taken only after the previous one has left the sequencer.
// Reset and stall:
//   reset loads the default registers and the initial state. A result waits
//   in the output register while the receiver stalls; a new request is
//   taken meanwhile and its result waits until the old one is taken.
// ----------------------------------------------------------------------------
module kalman_filter_2d_pos_vel #(
    parameter int WORD_BITS = kf2d_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = kf2d_pkg::FRAC_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // time_step[30:0], acceleration[62:31], meas_position[94:63],
    // meas_velocity[126:95], zero pad[127]
    input  logic [127:0] s_axis_tdata,
    // operation[2:0]
    input  logic [2:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // position[31:0], velocity[63:32], cov_pp[95:64], cov_pv[127:96],
    // cov_vp[159:128], cov_vv[191:160], gain_pp[223:192], gain_pv[255:224],
    // gain_vp[287:256], gain_vv[319:288]
    output logic [319:0] m_axis_tdata,
    // update_skipped[0]
    output logic         m_axis_tuser,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [31:0]  i_cfg_data
);
    localparam int W = WORD_BITS;
    localparam logic signed [64:0] WMAX = (65'sd1 <<< (W - 1)) - 65'sd1;
    localparam logic signed [64:0] WMIN = -WMAX - 65'sd1;
    localparam logic signed [64:0] I32MAX = 65'sd2147483647;
    localparam logic signed [64:0] I32MIN = -65'sd2147483648;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_RUN  = 4'b0010,
        ST_WAIT = 4'b0100,
        ST_OUT  = 4'b1000
    } t_state;

    t_state                       r_state;
    logic [kf2d_pkg::PC_BITS-1:0] r_pc;
    logic                         r_skip;
    logic [31:0]                  r_cfg [kf2d_pkg::NUM_CFG];
    logic signed [W-1:0]          r_st  [kf2d_pkg::NUM_ST];
    logic signed [W-1:0]          r_dt;
    logic signed [W-1:0]          r_acc;
    logic signed [W-1:0]          r_zp;
    logic signed [W-1:0]          r_zv;
    logic                         r_ovalid;
    logic [319:0]                 r_odata;
    logic                         r_oskip;

    kf2d_pkg::t_uinst             w_ui;
    kf2d_pkg::t_alu_req           w_req;
    logic signed [W-1:0]          w_a;
    logic signed [W-1:0]          w_b;
    logic                         w_done;
    logic signed [W-1:0]          w_res;
    logic                         w_is_alu;
    logic                         w_out_free;
    logic [kf2d_pkg::PC_BITS-1:0] w_start_pc;

    // clamp a wide signed value into the word range
    function automatic logic signed [W-1:0] f_load(input logic signed [64:0] v);
        logic signed [64:0] c;
        c = (v > WMAX) ? WMAX : ((v < WMIN) ? WMIN : v);
        return c[W-1:0];
    endfunction

    function automatic logic [31:0] f_out32(input logic signed [W-1:0] v);
        logic signed [64:0] e;
        e = 65'(v);
        e = (e > I32MAX) ? I32MAX : ((e < I32MIN) ? I32MIN : e);
        return e[31:0];
    endfunction

    function automatic logic signed [64:0] f_u31(input logic [31:0] v);
        return $signed({34'd0, v[30:0]});
    endfunction

    function automatic logic signed [64:0] f_s32(input logic [31:0] v);
        return 65'($signed(v));
    endfunction

    // operand source selection
    function automatic logic signed [W-1:0] f_src(input kf2d_pkg::t_slot s);
        logic signed [W-1:0] v;
        case (s)
            kf2d_pkg::S_DT:   v = r_dt;
            kf2d_pkg::S_ACC:  v = r_acc;
            kf2d_pkg::S_ZP:   v = r_zp;
            kf2d_pkg::S_ZV:   v = r_zv;
            kf2d_pkg::S_ZERO: v = '0;
            kf2d_pkg::S_ONE:  v = f_load(65'sd1 <<< FRAC_BITS);
            kf2d_pkg::S_HALF: v = f_load(65'sd1 <<< (FRAC_BITS - 1));
            kf2d_pkg::S_QP:   v = f_load(f_u31(r_cfg[kf2d_pkg::REG_Q_POS]));
            kf2d_pkg::S_QV:   v = f_load(f_u31(r_cfg[kf2d_pkg::REG_Q_VEL]));
            kf2d_pkg::S_RP:   v = f_load(f_u31(r_cfg[kf2d_pkg::REG_R_POS]));
            kf2d_pkg::S_RV:   v = f_load(f_u31(r_cfg[kf2d_pkg::REG_R_VEL]));
            kf2d_pkg::S_IP:   v = f_load(f_s32(r_cfg[kf2d_pkg::REG_INIT_POS]));
            kf2d_pkg::S_IV:   v = f_load(f_s32(r_cfg[kf2d_pkg::REG_INIT_VEL]));
            kf2d_pkg::S_IPV:  v = f_load(f_u31(r_cfg[kf2d_pkg::REG_INIT_PPV]));
            kf2d_pkg::S_IVV:  v = f_load(f_u31(r_cfg[kf2d_pkg::REG_INIT_VVV]));
            default:          v = r_st[s[4:0]];
        endcase
        return v;
    endfunction

    // current microinstruction and shared unit request
    assign w_ui     = kf2d_pkg::f_ucode(r_pc);
    assign w_a      = f_src(w_ui.a);
    assign w_b      = f_src(w_ui.b);
    assign w_is_alu = (w_ui.op == kf2d_pkg::UC_ADD) || (w_ui.op == kf2d_pkg::UC_SUB) ||
                      (w_ui.op == kf2d_pkg::UC_MUL) || (w_ui.op == kf2d_pkg::UC_DIV) ||
                      (w_ui.op == kf2d_pkg::UC_DIVP);
    assign w_req.start = (r_state == ST_RUN) && w_is_alu;
    assign w_req.op    = w_ui.op;

    kf2d_alu #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_a     (w_a),
        .i_b     (w_b),
        .o_done  (w_done),
        .o_res   (w_res)
    );

    // program entry for each operation
    always_comb begin
        unique case (s_axis_tuser)
            kf2d_pkg::OP_RESTART:  w_start_pc = kf2d_pkg::PC_RESTART;
            kf2d_pkg::OP_PREDICT:  w_start_pc = kf2d_pkg::PC_PREDICT;
            kf2d_pkg::OP_PRED_ACC: w_start_pc = kf2d_pkg::PC_PRED_ACC;
            kf2d_pkg::OP_UPD_POS:  w_start_pc = kf2d_pkg::PC_UPD_POS;
            kf2d_pkg::OP_UPD_BOTH: w_start_pc = kf2d_pkg::PC_UPD_BOTH;
            default:               w_start_pc = kf2d_pkg::PC_HALT;
        endcase
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_out_free    = !r_ovalid || m_axis_tready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < kf2d_pkg::NUM_CFG; i++) begin
                r_cfg[i] <= kf2d_pkg::CFG_RESET[i];
            end
        end else if (i_cfg_we) begin
            if (i_cfg_idx == kf2d_pkg::REG_INIT_POS || i_cfg_idx == kf2d_pkg::REG_INIT_VEL) begin
                r_cfg[i_cfg_idx] <= i_cfg_data;
            end else begin
                r_cfg[i_cfg_idx] <= {1'b0, i_cfg_data[30:0]};
            end
        end
    end

    // sequencer and filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pc    <= '0;
            r_skip  <= 1'b0;
            for (int i = 0; i < kf2d_pkg::NUM_ST; i++) begin
                r_st[i] <= '0;
            end
            r_st[5'(kf2d_pkg::S_POS)] <=
                f_load(f_s32(kf2d_pkg::CFG_RESET[kf2d_pkg::REG_INIT_POS]));
            r_st[5'(kf2d_pkg::S_VEL)] <=
                f_load(f_s32(kf2d_pkg::CFG_RESET[kf2d_pkg::REG_INIT_VEL]));
            r_st[5'(kf2d_pkg::S_P0)]  <=
                f_load(f_u31(kf2d_pkg::CFG_RESET[kf2d_pkg::REG_INIT_PPV]));
            r_st[5'(kf2d_pkg::S_P3)]  <=
                f_load(f_u31(kf2d_pkg::CFG_RESET[kf2d_pkg::REG_INIT_VVV]));
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_dt    <= f_load(f_u31(s_axis_tdata[31:0]));
                        r_acc   <= f_load(f_s32(s_axis_tdata[62:31]));
                        r_zp    <= f_load(f_s32(s_axis_tdata[94:63]));
                        r_zv    <= f_load(f_s32(s_axis_tdata[126:95]));
                        r_pc    <= w_start_pc;
                        r_skip  <= 1'b0;
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    case (w_ui.op)
                        kf2d_pkg::UC_END: r_state <= ST_OUT;
                        kf2d_pkg::UC_JMP: r_pc <= w_ui.tgt;
                        kf2d_pkg::UC_BRZ: begin
                            if (w_a == '0) begin
                                r_skip  <= 1'b1;
                                r_state <= ST_OUT;
                            end else begin
                                r_pc <= r_pc + 1'b1;
                            end
                        end
                        default: r_state <= ST_WAIT;
                    endcase
                end
                ST_WAIT: begin
                    if (w_done) begin
                        if (w_ui.d < kf2d_pkg::S_DT) begin
                            r_st[w_ui.d[4:0]] <= w_res;
                        end
                        r_pc    <= r_pc + 1'b1;
                        r_state <= ST_RUN;
                    end
                end
                ST_OUT: begin
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == ST_OUT && w_out_free) begin
            r_ovalid <= 1'b1;
            r_oskip  <= r_skip;
            r_odata  <= {f_out32(r_st[5'(kf2d_pkg::S_K3)]), f_out32(r_st[5'(kf2d_pkg::S_K2)]),
                         f_out32(r_st[5'(kf2d_pkg::S_K1)]), f_out32(r_st[5'(kf2d_pkg::S_K0)]),
                         f_out32(r_st[5'(kf2d_pkg::S_P3)]), f_out32(r_st[5'(kf2d_pkg::S_P2)]),
                         f_out32(r_st[5'(kf2d_pkg::S_P1)]), f_out32(r_st[5'(kf2d_pkg::S_P0)]),
                         f_out32(r_st[5'(kf2d_pkg::S_VEL)]),
                         f_out32(r_st[5'(kf2d_pkg::S_POS)])};
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_oskip;

endmodule

// ===== rtl/kf2d_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kf2d_checker: port-level checks for the Kalman filter
// Watches the request and result channels of the top level over time.
// ----------------------------------------------------------------------------
module kf2d_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [319:0] m_axis_tdata,
    input logic         m_axis_tuser
);
    // a taken request keeps the filter busy for at least the next cycle
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while filter still busy");

    // no result right after reset
    a_quiet_after_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result shown right after reset");

    // a stalled result holds
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

endmodule

bind kalman_filter_2d_pos_vel kf2d_checker u_kf2d_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
